// File: src/owtr_pkg.sv
// Shared types and constants for the one-wire temperature reader.
// No dependencies; imported by owtr_seq, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package owtr_pkg;

  // Sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_TAIL = 4'd3,
    PH_WR_LOW   = 4'd4,
    PH_WR_HOLD  = 4'd5,
    PH_WR_REC   = 4'd6,
    PH_CONV     = 4'd7,
    PH_RD_LOW   = 4'd8,
    PH_RD_WAIT  = 4'd9,
    PH_RD_HOLD  = 4'd10
  } owtr_phase_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_RESET_LOW      = 3'd0;
  localparam logic [2:0] CFG_PRESENCE_SMP   = 3'd1;
  localparam logic [2:0] CFG_RESET_TAIL     = 3'd2;
  localparam logic [2:0] CFG_SLOT_LOW       = 3'd3;
  localparam logic [2:0] CFG_WRITE_HOLD     = 3'd4;
  localparam logic [2:0] CFG_READ_SMP       = 3'd5;
  localparam logic [2:0] CFG_READ_HOLD      = 3'd6;
  localparam logic [2:0] CFG_CONVERT_WAIT   = 3'd7;

  localparam int CFG_DATA_W = 20;
  localparam int TICK_W     = 20;

  // Command bytes
  localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
  localparam logic [7:0] CMD_CONVERT  = 8'h44;
  localparam logic [7:0] CMD_RD_SCRPD = 8'hBE;

  // Step numbers with special meaning
  localparam logic [2:0] STEP_CONV_DONE = 3'd2;  // both convert-phase bytes sent
  localparam logic [2:0] STEP_RD_LOW    = 3'd4;  // reading the low temperature byte
  localparam logic [2:0] STEP_RD_HIGH   = 3'd5;

  typedef struct packed {
    logic [9:0]  reset_low;
    logic [7:0]  presence_smp;
    logic [9:0]  reset_tail;
    logic [3:0]  slot_low;
    logic [7:0]  write_hold;
    logic [5:0]  read_smp;
    logic [7:0]  read_hold;
    logic [19:0] convert_wait;
  } owtr_cfg_t;

  typedef struct packed {
    owtr_phase_t        phase;
    logic [TICK_W-1:0]  tick_count;
    logic [2:0]         bit_index;
    logic [2:0]         step_index;
    logic [7:0]         shift_byte;
    logic [7:0]         low_byte;
    logic [15:0]        temperature;
    logic               presence_fault;
  } owtr_state_t;

  typedef struct packed {
    logic drive_low;
    logic busy;
    logic done;
  } owtr_flags_t;

  // Command byte sent at a given write step
  function automatic logic [7:0] cmd_byte(input logic [1:0] step);
    logic [7:0] b;
    unique case (step)
      2'd0:    b = CMD_SKIP_ROM;
      2'd1:    b = CMD_CONVERT;
      2'd2:    b = CMD_SKIP_ROM;
      default: b = CMD_RD_SCRPD;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: src/owtr_tenths.sv
// Raw 1/16-degree two's complement reading to tenths of a degree, truncated toward zero.
// Pure combinational; needs no package, instanced by owtr_seq.
`timescale 1ns / 1ps
`default_nettype none

module owtr_tenths (
  input  wire logic [15:0] raw,
  output logic      [15:0] tenths
);

  logic        neg;
  logic [15:0] mag;
  logic [19:0] prod;
  logic [15:0] scaled;

  always_comb begin
    neg    = raw[15];
    mag    = neg ? (16'd0 - raw) : raw;
    // x10 as x8 + x2
    prod   = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0};
    scaled = prod[19:4];
    tenths = neg ? (16'd0 - scaled) : scaled;
  end

endmodule

`default_nettype wire

// File: src/owtr_seq.sv
// Next-state logic of the one-wire read sequencer: one bus tick per evaluation.
// Depends on owtr_pkg and owtr_tenths.
`timescale 1ns / 1ps
`default_nettype none

module owtr_seq
  import owtr_pkg::*;
(
  input  wire owtr_state_t cur,
  input  wire owtr_cfg_t   cfg,
  input  wire logic        start_req,
  input  wire logic        line_level,
  output owtr_state_t      nxt,
  output owtr_flags_t      flags
);

  logic [TICK_W-1:0] lim;
  logic [TICK_W-1:0] lim_m1;
  logic              hit;
  logic [TICK_W-1:0] tick_adv;
  logic [15:0]       tenths;
  logic [2:0]        step_inc;

  owtr_tenths u_tenths (
    .raw    ({cur.shift_byte, cur.low_byte}),
    .tenths (tenths)
  );

  // Shared tick timer: limit picked by phase, zero acts as one
  always_comb begin
    unique case (cur.phase)
      PH_RST_LOW:             lim = TICK_W'(cfg.reset_low);
      PH_RST_WAIT:            lim = TICK_W'(cfg.presence_smp);
      PH_RST_TAIL:            lim = TICK_W'(cfg.reset_tail);
      PH_WR_LOW, PH_RD_LOW:   lim = TICK_W'(cfg.slot_low);
      PH_WR_HOLD:             lim = TICK_W'(cfg.write_hold);
      PH_RD_WAIT:             lim = TICK_W'(cfg.read_smp);
      PH_RD_HOLD:             lim = TICK_W'(cfg.read_hold);
      PH_CONV:                lim = cfg.convert_wait;
      default:                lim = TICK_W'(1);
    endcase
    lim_m1   = (lim == '0) ? '0 : (lim - TICK_W'(1));
    hit      = (cur.tick_count >= lim_m1);
    tick_adv = hit ? '0 : (cur.tick_count + TICK_W'(1));
  end

  always_comb begin
    nxt             = cur;
    flags.drive_low = 1'b0;
    flags.busy      = (cur.phase != PH_IDLE);
    flags.done      = 1'b0;
    step_inc        = cur.step_index + 3'd1;

    unique case (cur.phase)
      PH_IDLE: begin
        if (start_req) begin
          nxt.presence_fault = 1'b0;
          nxt.step_index     = '0;
          nxt.tick_count     = '0;
          nxt.phase          = PH_RST_LOW;
        end
      end
      PH_RST_LOW: begin
        flags.drive_low = 1'b1;
        nxt.tick_count  = tick_adv;
        if (hit) nxt.phase = PH_RST_WAIT;
      end
      PH_RST_WAIT: begin
        nxt.tick_count = tick_adv;
        if (hit) begin
          if (line_level) nxt.presence_fault = 1'b1;
          nxt.phase = PH_RST_TAIL;
        end
      end
      PH_RST_TAIL: begin
        nxt.tick_count = tick_adv;
        if (hit) begin
          nxt.bit_index = '0;
          if (cur.step_index < STEP_RD_LOW) begin
            nxt.shift_byte = cmd_byte(cur.step_index[1:0]);
            nxt.phase      = PH_WR_LOW;
          end else begin
            nxt.shift_byte = '0;
            nxt.phase      = PH_RD_LOW;
          end
        end
      end
      PH_WR_LOW: begin
        flags.drive_low = 1'b1;
        nxt.tick_count  = tick_adv;
        if (hit) nxt.phase = PH_WR_HOLD;
      end
      PH_WR_HOLD: begin
        flags.drive_low = ~cur.shift_byte[0];
        nxt.tick_count  = tick_adv;
        if (hit) nxt.phase = PH_WR_REC;
      end
      PH_WR_REC: begin
        nxt.tick_count = '0;
        nxt.shift_byte = cur.shift_byte >> 1;
        if (cur.bit_index == 3'd7) begin
          nxt.bit_index  = '0;
          nxt.step_index = step_inc;
          if (step_inc == STEP_CONV_DONE) begin
            nxt.phase = (cfg.convert_wait == '0) ? PH_RST_LOW : PH_CONV;
          end else if (step_inc < STEP_RD_LOW) begin
            nxt.shift_byte = cmd_byte(step_inc[1:0]);
            nxt.phase      = PH_WR_LOW;
          end else begin
            nxt.shift_byte = '0;
            nxt.phase      = PH_RD_LOW;
          end
        end else begin
          nxt.bit_index = cur.bit_index + 3'd1;
          nxt.phase     = PH_WR_LOW;
        end
      end
      PH_CONV: begin
        if (cfg.convert_wait == '0 || hit) begin
          nxt.tick_count = '0;
          nxt.phase      = PH_RST_LOW;
        end else begin
          nxt.tick_count = tick_adv;
        end
      end
      PH_RD_LOW: begin
        flags.drive_low = 1'b1;
        nxt.tick_count  = tick_adv;
        if (hit) nxt.phase = PH_RD_WAIT;
      end
      PH_RD_WAIT: begin
        nxt.tick_count = tick_adv;
        if (hit) begin
          nxt.shift_byte = {line_level, cur.shift_byte[7:1]};
          nxt.phase      = PH_RD_HOLD;
        end
      end
      PH_RD_HOLD: begin
        nxt.tick_count = tick_adv;
        if (hit) begin
          if (cur.bit_index == 3'd7) begin
            nxt.bit_index = '0;
            if (cur.step_index == STEP_RD_LOW) begin
              nxt.low_byte   = cur.shift_byte;
              nxt.step_index = STEP_RD_HIGH;
              nxt.shift_byte = '0;
              nxt.phase      = PH_RD_LOW;
            end else begin
              nxt.temperature = tenths;
              flags.done      = 1'b1;
              nxt.step_index  = '0;
              nxt.phase       = PH_IDLE;
            end
          end else begin
            nxt.bit_index = cur.bit_index + 3'd1;
            nxt.phase     = PH_RD_LOW;
          end
        end
      end
      default: begin
        nxt.phase      = PH_IDLE;
        nxt.tick_count = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/one_wire_temperature_reader_unit.sv
// Top level of the one-wire temperature reader: config registers, sequencer state,
// result register and handshakes. Depends on owtr_pkg, owtr_seq (and owtr_tenths).
`timescale 1ns / 1ps
`default_nettype none

// One-wire master that performs a full temperature read of a single device:
// reset/presence, skip ROM, convert, conversion wait, reset, skip ROM, read
// scratchpad, then the two temperature bytes LSB first. Every input transaction
// is one bus tick carrying the start request and the sampled bus level; every
// input transaction yields exactly one output transaction carrying the open-drain
// drive, busy, a one-tick done pulse, the temperature in tenths of a degree
// (truncated toward zero) and the no-presence flag. Throughput is one transaction
// per clock: the sequencer state and a one-deep result register are updated on
// the same edge that accepts a tick, so in_ready stays high unless the result
// register holds an untaken transaction while out_ready is low. out_valid is
// set by the edge that accepts a tick. Drive and busy reflect the phase before
// the tick; done, temperature and no-presence reflect the state after it. The
// configuration registers (tick counts) come up at their reset defaults and are
// written through cfg_wen/cfg_index/cfg_wdata, masked to each register's width.
module one_wire_temperature_reader_unit
  import owtr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // tick input channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_start_req,
  input  wire logic                  in_line_level,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_drive_low,
  output logic                       out_busy_res,
  output logic                       out_done_res,
  output logic signed [15:0]         out_temperature_tenths,
  output logic                       out_no_presence,
  // configuration write port
  input  wire logic                  cfg_wen,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  owtr_cfg_t   cfg_r;
  owtr_state_t st_r;
  owtr_state_t st_nxt;
  owtr_flags_t flags;
  logic        in_acc;

  logic        out_valid_r;
  logic        drive_r;
  logic        busy_r;
  logic        done_r;
  logic [15:0] temp_r;
  logic        nopres_r;

  // Result register frees up when empty or being drained this cycle.
  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  // Configuration registers; each write is truncated to the field width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low    <= 10'd480;
      cfg_r.presence_smp <= 8'd70;
      cfg_r.reset_tail   <= 10'd410;
      cfg_r.slot_low     <= 4'd2;
      cfg_r.write_hold   <= 8'd60;
      cfg_r.read_smp     <= 6'd12;
      cfg_r.read_hold    <= 8'd50;
      cfg_r.convert_wait <= 20'd750000;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_RESET_LOW:    cfg_r.reset_low    <= cfg_wdata[9:0];
        CFG_PRESENCE_SMP: cfg_r.presence_smp <= cfg_wdata[7:0];
        CFG_RESET_TAIL:   cfg_r.reset_tail   <= cfg_wdata[9:0];
        CFG_SLOT_LOW:     cfg_r.slot_low     <= cfg_wdata[3:0];
        CFG_WRITE_HOLD:   cfg_r.write_hold   <= cfg_wdata[7:0];
        CFG_READ_SMP:     cfg_r.read_smp     <= cfg_wdata[5:0];
        CFG_READ_HOLD:    cfg_r.read_hold    <= cfg_wdata[7:0];
        CFG_CONVERT_WAIT: cfg_r.convert_wait <= cfg_wdata;
        default:          cfg_r              <= cfg_r;
      endcase
    end
  end

  // One bus tick of sequencer logic
  owtr_seq u_seq (
    .cur        (st_r),
    .cfg        (cfg_r),
    .start_req  (in_start_req),
    .line_level (in_line_level),
    .nxt        (st_nxt),
    .flags      (flags)
  );

  // Sequencer state advances only on an accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: PH_IDLE, default: '0};
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      drive_r  <= flags.drive_low;
      busy_r   <= flags.busy;
      done_r   <= flags.done;
      temp_r   <= st_nxt.temperature;
      nopres_r <= st_nxt.presence_fault;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_drive_low          = drive_r;
  assign out_busy_res           = busy_r;
  assign out_done_res           = done_r;
  assign out_temperature_tenths = $signed(temp_r);
  assign out_no_presence        = nopres_r;

`ifndef SYNTH
  // A done pulse only comes out of a running sequence.
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res) |-> out_busy_res)
    else $error("done without busy");

  // An accepted start while idle opens the reset pulse on the next tick.
  a_start_rst: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && st_r.phase == PH_IDLE && in_start_req) |=> (st_r.phase == PH_RST_LOW))
    else $error("start did not begin reset pulse");

  // Every accepted tick shows up in the result register.
  a_acc_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid)
    else $error("accepted tick lost");

  // State only moves on accepted ticks.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_acc && $past(rst_n)) |=> $stable(st_r))
    else $error("state moved without a tick");
`endif

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the one-wire temperature reader: directed reads, then random ticks.
// Depends on owtr_pkg and one_wire_temperature_reader_unit, and through it on owtr_seq and owtr_tenths.
`timescale 1ns / 1ps

module testbench;
  import owtr_pkg::*;

  // Timing sets used by the directed reads
  typedef enum logic [2:0] {
    SET_DEFAULT,
    SET_ZERO,
    SET_FAST,
    SET_LONG_CONV,
    SET_MIXED
  } timing_set_t;

  // One directed read: which timing set, what the device answers, and,
  // where it is obvious, the temperature and presence flag it must end with.
  typedef struct packed {
    logic               start;      // 0: a few idle ticks only
    timing_set_t        timing;
    logic [15:0]        raw;        // scratchpad temperature the bus will return
    logic               present;    // device answers the reset pulses
    logic [19:0]        conv_cut;   // nonzero: rewrite the conversion wait while in it
    logic               check;
    logic signed [15:0] tenths;
    logic               nopres;
  } drill_row_t;

  // One result transaction
  typedef struct packed {
    logic               drive_low;
    logic               busy;
    logic               done;
    logic signed [15:0] tenths;
    logic               no_presence;
  } reading_t;

  localparam owtr_cfg_t CFG_AT_RESET =
    '{10'd480, 8'd70, 10'd410, 4'd2, 8'd60, 6'd12, 8'd50, 20'd750000};
  localparam int RANDOM_TICKS = 200;

  // Directed reads: extremes of the 16-bit raw value, sign handling of the
  // truncation, missing presence, all-zero and all-one timings, and the widest
  // conversion wait rewritten mid-sequence (both still running and already past).
  drill_row_t drill_plan [8] = '{
    '{1'b0, SET_DEFAULT,   16'h0000, 1'b1, 20'd0,   1'b1,  16'sd0,     1'b0},
    '{1'b1, SET_LONG_CONV, 16'h0191, 1'b1, 20'd100, 1'b1,  16'sd250,   1'b0},
    '{1'b1, SET_ZERO,      16'h7FFF, 1'b1, 20'd0,   1'b1,  16'sd20479, 1'b0},
    '{1'b1, SET_ZERO,      16'h8000, 1'b1, 20'd0,   1'b1, -16'sd20480, 1'b0},
    '{1'b1, SET_FAST,      16'hFFFF, 1'b1, 20'd0,   1'b1,  16'sd0,     1'b0},
    '{1'b1, SET_FAST,      16'hFFF8, 1'b0, 20'd0,   1'b1, -16'sd5,     1'b1},
    '{1'b1, SET_LONG_CONV, 16'hFC90, 1'b1, 20'd5,   1'b1, -16'sd550,   1'b0},
    '{1'b1, SET_MIXED,     16'h07D0, 1'b0, 20'd0,   1'b1,  16'sd1250,  1'b1}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_start_req;
  logic                  in_line_level;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_drive_low;
  logic                  out_busy_res;
  logic                  out_done_res;
  logic signed [15:0]    out_temperature_tenths;
  logic                  out_no_presence;
  logic                  cfg_wen;
  logic [2:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  one_wire_temperature_reader_unit u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_start_req           (in_start_req),
    .in_line_level          (in_line_level),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_drive_low          (out_drive_low),
    .out_busy_res           (out_busy_res),
    .out_done_res           (out_done_res),
    .out_temperature_tenths (out_temperature_tenths),
    .out_no_presence        (out_no_presence),
    .cfg_wen                (cfg_wen),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Reader model: own copy of the sequencer state and the timing registers.
  // ---------------------------------------------------------------------------
  owtr_phase_t m_phase;
  int unsigned m_ticks;
  logic [2:0]  m_bit;
  logic [2:0]  m_step;
  logic [7:0]  m_shift;
  logic [7:0]  m_low;
  logic [15:0] m_temp;
  logic        m_fault;
  owtr_cfg_t   m_cfg;

  logic [7:0] cmd_seq [4] = '{CMD_SKIP_ROM, CMD_CONVERT, CMD_SKIP_ROM, CMD_RD_SCRPD};

  reading_t expected_readings [$];
  reading_t last_reading;
  int       errors;
  int       burst_left;
  logic [15:0] cur_raw;       // what the simulated device returns in the read slots
  logic        cur_present;

  // Counts one tick of a timed phase; a zero limit behaves as one tick.
  function automatic bit timer_expired(input int unsigned lim);
    if (lim == 0) lim = 1;
    if (m_ticks + 1 >= lim) begin
      m_ticks = 0;
      return 1'b1;
    end
    m_ticks++;
    return 1'b0;
  endfunction

  function automatic void open_byte();
    m_bit = '0;
    if (m_step < 3'd4) begin
      m_shift = cmd_seq[m_step[1:0]];
      m_phase = PH_WR_LOW;
    end else begin
      m_shift = '0;
      m_phase = PH_RD_LOW;
    end
  endfunction

  // 1/16 degree two's complement to tenths, truncated toward zero
  function automatic logic [15:0] raw_to_tenths(input logic [15:0] raw);
    int unsigned mag;
    if (raw[15]) begin
      mag = 32'h10000 - raw;
      return 16'(32'h10000 - ((mag * 10) >> 4));
    end
    return 16'((int'(raw) * 10) >> 4);
  endfunction

  // Advances the model by one accepted tick and returns the result it gives.
  function automatic reading_t step_reader(input bit start, input bit level);
    reading_t r;
    r = '0;
    r.busy = (m_phase != PH_IDLE);
    case (m_phase)
      PH_IDLE: begin
        if (start) begin
          m_fault = 1'b0;
          m_step  = '0;
          m_ticks = 0;
          m_phase = PH_RST_LOW;
        end
      end
      PH_RST_LOW: begin
        r.drive_low = 1'b1;
        if (timer_expired(m_cfg.reset_low)) m_phase = PH_RST_WAIT;
      end
      PH_RST_WAIT: begin
        if (timer_expired(m_cfg.presence_smp)) begin
          if (level) m_fault = 1'b1;
          m_phase = PH_RST_TAIL;
        end
      end
      PH_RST_TAIL: begin
        if (timer_expired(m_cfg.reset_tail)) open_byte();
      end
      PH_WR_LOW: begin
        r.drive_low = 1'b1;
        if (timer_expired(m_cfg.slot_low)) m_phase = PH_WR_HOLD;
      end
      PH_WR_HOLD: begin
        r.drive_low = ~m_shift[0];
        if (timer_expired(m_cfg.write_hold)) m_phase = PH_WR_REC;
      end
      PH_WR_REC: begin
        m_shift = m_shift >> 1;
        if (m_bit == 3'd7) begin
          m_bit  = '0;
          m_step = m_step + 3'd1;
          if (m_step == STEP_CONV_DONE) begin
            m_phase = (m_cfg.convert_wait == '0) ? PH_RST_LOW : PH_CONV;
          end else begin
            open_byte();
          end
        end else begin
          m_bit   = m_bit + 3'd1;
          m_phase = PH_WR_LOW;
        end
        m_ticks = 0;
      end
      PH_CONV: begin
        if (m_cfg.convert_wait == '0) begin
          m_ticks = 0;
          m_phase = PH_RST_LOW;
        end else if (timer_expired(m_cfg.convert_wait)) begin
          m_ticks = 0;
          m_phase = PH_RST_LOW;
        end
      end
      PH_RD_LOW: begin
        r.drive_low = 1'b1;
        if (timer_expired(m_cfg.slot_low)) m_phase = PH_RD_WAIT;
      end
      PH_RD_WAIT: begin
        if (timer_expired(m_cfg.read_smp)) begin
          m_shift = {level, m_shift[7:1]};
          m_phase = PH_RD_HOLD;
        end
      end
      PH_RD_HOLD: begin
        if (timer_expired(m_cfg.read_hold)) begin
          if (m_bit == 3'd7) begin
            m_bit = '0;
            if (m_step == STEP_RD_LOW) begin
              m_low   = m_shift;
              m_step  = STEP_RD_HIGH;
              m_shift = '0;
              m_phase = PH_RD_LOW;
            end else begin
              m_temp  = raw_to_tenths({m_shift, m_low});
              r.done  = 1'b1;
              m_step  = '0;
              m_phase = PH_IDLE;
            end
          end else begin
            m_bit   = m_bit + 3'd1;
            m_phase = PH_RD_LOW;
          end
        end
      end
      default: begin
        m_phase = PH_IDLE;
        m_ticks = 0;
      end
    endcase
    r.tenths      = m_temp;
    r.no_presence = m_fault;
    return r;
  endfunction

  // Bus level the simulated device puts on the line for the next tick:
  // presence answer during the presence wait, data bit during a read wait.
  function automatic bit line_for_phase(input bit noisy);
    if (noisy) return $urandom_range(1, 0);
    case (m_phase)
      PH_RST_WAIT: return ~cur_present;
      PH_RD_WAIT:  return cur_raw[((m_step == STEP_RD_HIGH) ? 8 : 0) + m_bit];
      default:     return $urandom_range(1, 0);
    endcase
  endfunction

  function automatic owtr_cfg_t timing_for(input timing_set_t s);
    case (s)
      SET_ZERO:      return '0;
      SET_FAST:      return '{10'd1, 8'd1, 10'd1, 4'd1, 8'd1, 6'd1, 8'd1, 20'd1};
      SET_LONG_CONV: return '{10'd1, 8'd1, 10'd1, 4'd1, 8'd1, 6'd1, 8'd1, 20'd1048575};
      SET_MIXED:     return '{10'd3, 8'd1, 10'd2, 4'd2, 8'd1, 6'd3, 8'd1, 20'd0};
      default:       return CFG_AT_RESET;
    endcase
  endfunction

  // Short timings keep sequences quick; now and then a longer slot.
  function automatic owtr_cfg_t random_timing();
    owtr_cfg_t c;
    c.reset_low    = $urandom_range(3, 0);
    c.presence_smp = $urandom_range(3, 0);
    c.reset_tail   = $urandom_range(3, 0);
    c.slot_low     = ($urandom_range(4, 0) == 0) ? $urandom_range(15, 0) : $urandom_range(2, 0);
    c.write_hold   = $urandom_range(3, 0);
    c.read_smp     = ($urandom_range(4, 0) == 0) ? $urandom_range(63, 4) : $urandom_range(3, 0);
    c.read_hold    = $urandom_range(3, 0);
    c.convert_wait = $urandom_range(6, 0);
    return c;
  endfunction

  function automatic logic [15:0] random_raw();
    case ($urandom_range(11, 0))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic void flag_mismatch(input string what, input reading_t want,
                                        input reading_t got);
    if (errors < 10) begin
      $display("%0t %s: expected drive=%0b busy=%0b done=%0b tenths=%0d nopres=%0b",
               $realtime, what, want.drive_low, want.busy, want.done, want.tenths,
               want.no_presence);
      $display("    got drive=%0b busy=%0b done=%0b tenths=%0d nopres=%0b",
               got.drive_low, got.busy, got.done, got.tenths, got.no_presence);
    end
    errors++;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers. All drive with nonblocking assignments at a clock edge.
  // ---------------------------------------------------------------------------

  // Writes one timing register; bits above its width carry junk that the
  // block must drop. Leaves cfg_wen high: the caller lowers it after the last write.
  task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
    int         w;
    logic [19:0] junk;
    logic [19:0] data;
    case (idx)
      CFG_RESET_LOW, CFG_RESET_TAIL:                  w = 10;
      CFG_PRESENCE_SMP, CFG_WRITE_HOLD, CFG_READ_HOLD: w = 8;
      CFG_SLOT_LOW:                                   w = 4;
      CFG_READ_SMP:                                   w = 6;
      default:                                        w = 20;
    endcase
    junk = $urandom;
    data = val | ((w < 20) ? (junk << w) : 20'd0);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_RESET_LOW:    m_cfg.reset_low    = data[9:0];
      CFG_PRESENCE_SMP: m_cfg.presence_smp = data[7:0];
      CFG_RESET_TAIL:   m_cfg.reset_tail   = data[9:0];
      CFG_SLOT_LOW:     m_cfg.slot_low     = data[3:0];
      CFG_WRITE_HOLD:   m_cfg.write_hold   = data[7:0];
      CFG_READ_SMP:     m_cfg.read_smp     = data[5:0];
      CFG_READ_HOLD:    m_cfg.read_hold    = data[7:0];
      default:          m_cfg.convert_wait = data;
    endcase
  endtask

  task automatic apply_timing(input owtr_cfg_t c);
    write_reg(CFG_RESET_LOW, c.reset_low);
    write_reg(CFG_PRESENCE_SMP, c.presence_smp);
    write_reg(CFG_RESET_TAIL, c.reset_tail);
    write_reg(CFG_SLOT_LOW, c.slot_low);
    write_reg(CFG_WRITE_HOLD, c.write_hold);
    write_reg(CFG_READ_SMP, c.read_smp);
    write_reg(CFG_READ_HOLD, c.read_hold);
    write_reg(CFG_CONVERT_WAIT, c.convert_wait);
    cfg_wen <= 1'b0;
  endtask

  // Waits until every result is in, then lets the one-deep output stage drain.
  task automatic settle();
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Sends one tick. The sender runs in bursts with random gaps in between.
  task automatic run_tick(input bit start, input bit noisy);
    int gap;
    bit level;
    if (burst_left == 0) begin
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(5, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(30, 1);
    end
    level = line_for_phase(noisy);
    in_valid      <= 1'b1;
    in_start_req  <= start;
    in_line_level <= level;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    expected_readings.push_back(step_reader(start, level));
  endtask

  // ---------------------------------------------------------------------------
  // Clock, limit, receiver and checker
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a run that has not finished by this time ends with an error.
  initial begin
    #1_000_000;
    $display("[one_wire_temperature_reader_unit] ERROR");
    $finish;
  end

  // Receiver: switches between always ready, coin-flip stalls, a fixed
  // one-in-four stall and rare stalls, each for a random stretch.
  initial begin
    int mode;
    int left;
    mode = 0;
    left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(3, 0);
        left = $urandom_range(80, 8);
      end
      left--;
      case (mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= $urandom_range(1, 0);
        2:       out_ready <= (left % 4) != 0;
        default: out_ready <= $urandom_range(7, 0) != 0;
      endcase
    end
  end

  // Every result transaction is matched against the oldest expectation.
  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_drive_low, out_busy_res, out_done_res, out_temperature_tenths,
             out_no_presence};
      last_reading = got;
      if (expected_readings.size() == 0) begin
        flag_mismatch("result with nothing expected", '0, got);
      end else begin
        want = expected_readings.pop_front();
        if (got.drive_low !== want.drive_low || got.busy !== want.busy ||
            got.done !== want.done || got.tenths !== want.tenths ||
            got.no_presence !== want.no_presence)
          flag_mismatch("result mismatch", want, got);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    drill_row_t row;
    reading_t   want;
    bit         cut_done;
    bit         st;
    int         rand_ticks;
    int         budget;
    int         n;

    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_start_req  <= 1'b0;
    in_line_level <= 1'b0;
    cfg_wen       <= 1'b0;
    cfg_index     <= CFG_RESET_LOW;
    cfg_wdata     <= '0;
    errors      = 0;
    burst_left  = 0;
    cur_raw     = '0;
    cur_present = 1'b1;
    last_reading = '0;
    rand_ticks  = 0;

    // model state after reset
    m_phase = PH_IDLE;
    m_ticks = 0;
    m_bit   = '0;
    m_step  = '0;
    m_shift = '0;
    m_low   = '0;
    m_temp  = '0;
    m_fault = 1'b0;
    m_cfg   = CFG_AT_RESET;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed reads. Start is toggled at random while busy; it must be ignored.
    foreach (drill_plan[i]) begin
      row = drill_plan[i];
      if (row.start) begin
        settle();
        apply_timing(timing_for(row.timing));
        cur_raw     = row.raw;
        cur_present = row.present;
        cut_done    = 1'b0;
        run_tick(1'b1, 1'b0);
        while (m_phase != PH_IDLE) begin
          // shorten the conversion wait once the block has spent 63 ticks in it
          if (row.conv_cut != '0 && !cut_done && m_phase == PH_CONV && m_ticks >= 63) begin
            in_valid <= 1'b0;
            settle();
            write_reg(CFG_CONVERT_WAIT, row.conv_cut);
            cfg_wen <= 1'b0;
            cut_done = 1'b1;
          end
          run_tick($urandom_range(1, 0), 1'b0);
        end
      end else begin
        repeat (4) run_tick(1'b0, 1'b0);
      end
      in_valid <= 1'b0;
      settle();
      if (row.check) begin
        want = last_reading;
        want.tenths      = row.tenths;
        want.no_presence = row.nopres;
        if (last_reading.tenths !== row.tenths || last_reading.no_presence !== row.nopres)
          flag_mismatch("final reading of directed read", want, last_reading);
      end
    end

    // Random part: new short timings per stretch, mostly complete reads with
    // random temperatures, occasional missing presence and stray bus noise.
    while (rand_ticks < RANDOM_TICKS) begin
      settle();
      apply_timing(random_timing());
      budget = $urandom_range(400, 120);
      n = 0;
      while (n < budget || m_phase != PH_IDLE) begin
        if (m_phase == PH_IDLE) begin
          st = $urandom_range(3, 0) != 0;
          if (st) begin
            cur_raw     = random_raw();
            cur_present = $urandom_range(7, 0) != 0;
          end
        end else begin
          st = $urandom_range(1, 0);
        end
        run_tick(st, $urandom_range(15, 0) == 0);
        n++;
      end
      rand_ticks += n;
      in_valid <= 1'b0;
    end

    while (expected_readings.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0 && expected_readings.size() == 0)
      $display("[one_wire_temperature_reader_unit] OK");
    else
      $display("[one_wire_temperature_reader_unit] ERROR");
    $finish;
  end

endmodule

// File: sim.f
src/owtr_pkg.sv
src/owtr_tenths.sv
src/owtr_seq.sv
src/one_wire_temperature_reader_unit.sv
tb/sv/testbench.sv
